// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the timer table top module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is checked at every clock edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dtt_pkg.sv =====
// ----------------------------------------------------------------------------
// dtt_pkg
// Types, codes and constants shared by the deadline timer table modules.
// ----------------------------------------------------------------------------
package dtt_pkg;

  localparam int DEFAULT_TIMER_SLOTS = 16;
  localparam int MAX_RESULTS         = 16;
  localparam int COUNT_W             = $clog2(MAX_RESULTS + 1);

  localparam int TPS_W     = 10;
  localparam int SEC_W     = 32;
  localparam int TAG_W     = 32;
  localparam int ORDER_W   = 32;
  localparam int SLOT_W    = 4;
  localparam int TIMEOUT_W = 16;
  localparam int MODE_W    = 2;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;

  localparam logic [TPS_W-1:0] TPS_RESET = 10'd10;

  typedef logic [MODE_W-1:0] mode_t;
  localparam mode_t MODE_TICK  = 2'd0;
  localparam mode_t MODE_START = 2'd1;
  localparam mode_t MODE_STOP  = 2'd2;
  localparam mode_t MODE_QUERY = 2'd3;

  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_START  = 2'd0;
  localparam kind_t KIND_STOP   = 2'd1;
  localparam kind_t KIND_QUERY  = 2'd2;
  localparam kind_t KIND_EXPIRY = 2'd3;

  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t STATUS_OK   = 2'd0;
  localparam status_t STATUS_MISS = 2'd1;
  localparam status_t STATUS_FULL = 2'd2;

  // One timer entry as held in the slot memory.
  typedef struct packed {
    logic [SEC_W-1:0]   sec;
    logic [TPS_W-1:0]   sub;
    logic [TAG_W-1:0]   tag;
    logic [ORDER_W-1:0] order;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic idx_clear;
    logic idx_inc;
    logic scan_rd;
    logic alloc;
    logic full;
    logic take;
    logic push;
    logic push_last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idx_last;
    logic slot_free;
    logic found;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/dtt_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtt_ctrl
// Controller of the deadline timer table: sequences free-slot searches,
// expiry scans and the hand-over of answers to the output register.
// ----------------------------------------------------------------------------
module dtt_ctrl
  import dtt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  mode_t    mode,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FREE,
    ST_SCAN,
    ST_LAST,
    ST_DECIDE,
    ST_PUSH
  } state_t;

  state_t             state;
  logic               hold_valid;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;

  assign in_ready   = (state == ST_IDLE);
  assign count_next = count + COUNT_W'(1);

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept    = 1'b1;
          cmd.idx_clear = 1'b1;
        end
      end
      ST_FREE: begin
        if (stat.slot_free) begin
          cmd.alloc = 1'b1;
        end else if (stat.idx_last) begin
          cmd.full = 1'b1;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        cmd.idx_inc = 1'b1;
      end
      ST_DECIDE: begin
        // A held expiry must leave before the next one takes its place.
        if (stat.found && (!hold_valid || stat.out_free)) begin
          cmd.take      = 1'b1;
          cmd.idx_clear = 1'b1;
          cmd.push      = hold_valid;
        end
      end
      ST_PUSH: begin
        if (stat.out_free) begin
          cmd.push      = 1'b1;
          cmd.push_last = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      hold_valid <= 1'b0;
      count      <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            hold_valid <= 1'b0;
            count      <= '0;
            case (mode)
              MODE_TICK:  state <= ST_SCAN;
              MODE_START: state <= ST_FREE;
              default:    state <= ST_PUSH;
            endcase
          end
        end
        ST_FREE: begin
          if (stat.slot_free || stat.idx_last) begin
            state <= ST_PUSH;
          end
        end
        ST_SCAN: begin
          if (stat.idx_last) begin
            state <= ST_LAST;
          end
        end
        ST_LAST: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (stat.found) begin
            if (cmd.take) begin
              hold_valid <= 1'b1;
              count      <= count_next;
              state      <= (count_next == COUNT_W'(MAX_RESULTS)) ? ST_PUSH : ST_SCAN;
            end
          end else begin
            state <= hold_valid ? ST_PUSH : ST_IDLE;
          end
        end
        ST_PUSH: begin
          if (stat.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/dtt_datapath.sv =====
// ----------------------------------------------------------------------------
// dtt_datapath
// Datapath of the deadline timer table: time base, slot memory, live bits,
// best-candidate search register, answer hold register and output register.
// ----------------------------------------------------------------------------
module dtt_datapath
  import dtt_pkg::*;
#(
  parameter int TIMER_SLOTS = DEFAULT_TIMER_SLOTS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [TPS_W-1:0]     cfg_data,
  input  mode_t                mode,
  input  logic [SLOT_W-1:0]    slot,
  input  logic [TIMEOUT_W-1:0] timeout_seconds,
  input  logic [TAG_W-1:0]     tag,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic                 out_ready,
  output logic                 out_valid,
  output kind_t                out_kind,
  output status_t              out_status,
  output logic [SLOT_W-1:0]    out_slot,
  output logic [TAG_W-1:0]     out_tag,
  output logic                 out_last
);

  localparam int IDX_W = $clog2(TIMER_SLOTS);

  logic [TPS_W-1:0]     ticks_per_second;
  logic [TPS_W-1:0]     tps_eff;
  logic [TPS_W:0]       sub_inc;
  logic                 sub_wrap;
  logic [SEC_W-1:0]     seconds_now;
  logic [TPS_W-1:0]     subtick_now;
  logic [ORDER_W-1:0]   start_sequence;

  logic [TIMER_SLOTS-1:0] live;
  entry_t                 mem [TIMER_SLOTS];
  entry_t                 rd_data;
  logic                   rd_valid;
  logic [IDX_W-1:0]       idx;
  logic [IDX_W-1:0]       idx_d;

  logic [TIMEOUT_W-1:0] timeout_q;
  logic [TAG_W-1:0]     tag_q;

  logic [IDX_W-1:0] slot_idx;
  logic             slot_hit;

  logic               cand;
  logic               first;
  logic               better;
  logic               best_found;
  logic [IDX_W-1:0]   best_idx;
  logic [SEC_W-1:0]   best_sec;
  logic [TPS_W-1:0]   best_sub;
  logic [ORDER_W-1:0] best_order;
  logic [TAG_W-1:0]   best_tag;

  kind_t             hold_kind;
  status_t           hold_status;
  logic [SLOT_W-1:0] hold_slot;
  logic [TAG_W-1:0]  hold_tag;

  logic is_tick;
  logic is_answer;

  // A register value of zero counts as one sub-tick per second.
  assign tps_eff  = (ticks_per_second == '0) ? TPS_W'(1) : ticks_per_second;
  assign sub_inc  = {1'b0, subtick_now} + (TPS_W + 1)'(1);
  assign sub_wrap = (sub_inc >= {1'b0, tps_eff});

  assign is_tick   = cmd.accept && (mode == MODE_TICK);
  assign is_answer = cmd.accept && ((mode == MODE_STOP) || (mode == MODE_QUERY));

  assign slot_idx = IDX_W'(slot);
  assign slot_hit = (int'(slot) < TIMER_SLOTS) && live[slot_idx];

  // Due when the deadline is at or before the current time; ordering is by
  // deadline, then by start sequence.
  assign cand   = rd_valid && live[idx_d] &&
                  ({rd_data.sec, rd_data.sub} <= {seconds_now, subtick_now});
  assign first  = (idx_d == '0);
  assign better = first || !best_found ||
                  ({rd_data.sec, rd_data.sub, rd_data.order} <
                   {best_sec, best_sub, best_order});

  assign stat.idx_last  = (idx == IDX_W'(TIMER_SLOTS - 1));
  assign stat.slot_free = !live[idx];
  assign stat.found     = best_found;
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= TPS_RESET;
      seconds_now      <= '0;
      subtick_now      <= '0;
      start_sequence   <= '0;
      live             <= '0;
      idx              <= '0;
      rd_valid         <= 1'b0;
      best_found       <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_write) begin
        ticks_per_second <= cfg_data;
      end
      if (is_tick) begin
        if (sub_wrap) begin
          subtick_now <= '0;
          seconds_now <= seconds_now + SEC_W'(1);
        end else begin
          subtick_now <= sub_inc[TPS_W-1:0];
        end
      end
      if (cmd.alloc) begin
        start_sequence <= start_sequence + ORDER_W'(1);
        live[idx]      <= 1'b1;
      end
      if (cmd.accept && (mode == MODE_STOP) && slot_hit) begin
        live[slot_idx] <= 1'b0;
      end
      if (cmd.take) begin
        live[best_idx] <= 1'b0;
      end

      if (cmd.idx_clear) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + IDX_W'(1);
      end
      rd_valid <= cmd.scan_rd;

      if (rd_valid) begin
        if (first) begin
          best_found <= cand;
        end else if (cand) begin
          best_found <= 1'b1;
        end
      end

      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Slot memory: one write port for start, one registered read port for scans.
  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      mem[idx] <= '{sec:   seconds_now + SEC_W'(timeout_q),
                    sub:   subtick_now,
                    tag:   tag_q,
                    order: start_sequence};
    end
    rd_data <= mem[idx];
  end

  always_ff @(posedge clk) begin
    idx_d <= idx;
    if (cmd.accept) begin
      timeout_q <= timeout_seconds;
      tag_q     <= tag;
    end
    if (cand && better) begin
      best_idx   <= idx_d;
      best_sec   <= rd_data.sec;
      best_sub   <= rd_data.sub;
      best_order <= rd_data.order;
      best_tag   <= rd_data.tag;
    end

    if (is_answer) begin
      hold_kind   <= (mode == MODE_STOP) ? KIND_STOP : KIND_QUERY;
      hold_status <= slot_hit ? STATUS_OK : STATUS_MISS;
      hold_slot   <= slot;
      hold_tag    <= '0;
    end else if (cmd.alloc) begin
      hold_kind   <= KIND_START;
      hold_status <= STATUS_OK;
      hold_slot   <= SLOT_W'(idx);
      hold_tag    <= '0;
    end else if (cmd.full) begin
      hold_kind   <= KIND_START;
      hold_status <= STATUS_FULL;
      hold_slot   <= '0;
      hold_tag    <= '0;
    end else if (cmd.take) begin
      hold_kind   <= KIND_EXPIRY;
      hold_status <= STATUS_OK;
      hold_slot   <= SLOT_W'(best_idx);
      hold_tag    <= best_tag;
    end

    // The output register takes the held answer before the hold is reloaded.
    if (cmd.push) begin
      out_kind   <= hold_kind;
      out_status <= hold_status;
      out_slot   <= hold_slot;
      out_tag    <= hold_tag;
      out_last   <= cmd.push_last;
    end
  end

endmodule

// ===== rtl/deadline_timer_table.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_table
// Table of one-shot deadline timers run from a sub-second tick.
// ----------------------------------------------------------------------------
// Commands enter on the s_ channel (tuser carries the mode: tick, start,
// stop or query); answers and expiries leave on the m_ channel, with tlast
// on the final result caused by each command. ticks_per_second is written
// through cfg_write and cfg_data; the user must write it only while the
// block is idle, and the block itself does not enforce this.
// One command is worked on at a time. Stop and query go from idle straight
// to the push state. Start searches the live bits for the lowest free slot,
// one slot a cycle. A tick runs one pass over the slot memory per expiry,
// one entry a cycle through its single read port, plus a closing pass that
// finds nothing; the closing pass is skipped once sixteen expiries have been
// taken. Each pass scans every slot, then goes through a last state and a
// decide state.
// Each result sits in an output register; a new command is accepted while
// it waits, and the block only holds back when a second result must leave
// while the first is still stalled by m_tready.
// Reset clears all slots, the time base and the start sequence, and sets
// ticks_per_second to 10. No clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module deadline_timer_table
  import dtt_pkg::*;
#(
  parameter int TIMER_SLOTS = DEFAULT_TIMER_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [TPS_W-1:0]      cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // s_tdata: slot [3:0], timeout_seconds [19:4], tag [51:20], zero [55:52]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // s_tuser: mode [1:0]
  input  logic [MODE_W-1:0]     s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // m_tdata: status [1:0], result_slot [5:2], result_tag [37:6], zero [39:38]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // m_tuser: kind [1:0]
  output logic [KIND_W-1:0]     m_tuser,
  output logic                  m_tlast
);

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  kind_t             out_kind;
  status_t           out_status;
  logic [SLOT_W-1:0] out_slot;
  logic [TAG_W-1:0]  out_tag;

  dtt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .mode     (s_tuser),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dtt_datapath #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .mode            (s_tuser),
    .slot            (s_tdata[3:0]),
    .timeout_seconds (s_tdata[19:4]),
    .tag             (s_tdata[51:20]),
    .cmd             (cmd),
    .stat            (stat),
    .out_ready       (m_tready),
    .out_valid       (m_tvalid),
    .out_kind        (out_kind),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_tag         (out_tag),
    .out_last        (m_tlast)
  );

  assign m_tdata = {2'b00, out_tag, out_slot, out_status};
  assign m_tuser = out_kind;

  `ASSERT_CLK(a_reset_empties_output, clk, rst |=> !m_tvalid, "output valid after reset")
  `ASSERT_RST(a_one_item_at_a_time, clk, rst,
              s_tvalid && s_tready |=> !s_tready, "second item taken while busy")
  `ASSERT_RST(a_answers_are_single, clk, rst,
              m_tvalid && (m_tuser != KIND_EXPIRY) |-> m_tlast, "command answer without last")
  `ASSERT_RST(a_answers_carry_no_tag, clk, rst,
              m_tvalid && (m_tuser != KIND_EXPIRY) |-> (m_tdata[37:6] == 32'd0),
              "command answer with a tag")
  `ASSERT_RST(a_full_only_on_start, clk, rst,
              m_tvalid && (m_tdata[1:0] == STATUS_FULL) |-> (m_tuser == KIND_START),
              "table full on a non-start result")

endmodule
